// File: src/siku_pkg.sv
// ----------------------------------------------------------------------------
// siku_pkg: shared types and constants for the swerve inverse kinematics unit
// Holds controller states, command/status bundles and the CORDIC constants.
// ----------------------------------------------------------------------------
package siku_pkg;

	// controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_PREP,
		ST_ROT,
		ST_GAIN_LO,
		ST_GAIN_HI,
		ST_FINISH,
		ST_PUBLISH
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic       load;
		logic       mul;
		logic       prep;
		logic       rot;
		logic       gain_lo;
		logic       gain_hi;
		logic       finish;
		logic       publish;
		logic [1:0] wheel;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic out_free;
		logic rot_last;
	} status_t;

	localparam int NUM_WHEELS = 3;
	localparam logic [1:0] LAST_WHEEL = 2'd2;

	// configuration register indexes
	localparam logic [2:0] REG_W0_POS_X     = 3'd0;
	localparam logic [2:0] REG_W0_POS_Y     = 3'd1;
	localparam logic [2:0] REG_W1_POS_X     = 3'd2;
	localparam logic [2:0] REG_W1_POS_Y     = 3'd3;
	localparam logic [2:0] REG_W2_POS_X     = 3'd4;
	localparam logic [2:0] REG_W2_POS_Y     = 3'd5;
	localparam logic [2:0] REG_INV_RADIUS   = 3'd6;
	localparam logic [2:0] REG_LOW_SPEED    = 3'd7;

	localparam logic [15:0] INV_RADIUS_RST = 16'd5120;
	localparam logic [15:0] LOW_SPEED_RST  = 16'd10;

	// cordic gain compensation, q30
	localparam logic [29:0] GAIN_Q30 = 30'd652032874;
	localparam logic [14:0] SPEED_MAX = 15'd25600;

	// datapath widths
	localparam int XW = 33;
	localparam int ZW = 34;

	// arctangent of 2^-k in units of pi/2^31
	localparam logic [29:0] ATAN_TAB [24] = '{
		30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
		30'd42667331,  30'd21354465,  30'd10679838,  30'd5340245,
		30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
		30'd166886,    30'd83443,     30'd41722,     30'd20861,
		30'd10430,     30'd5215,      30'd2608,      30'd1304,
		30'd652,       30'd326,       30'd163,       30'd81
	};

endpackage

// File: src/siku_ctrl.sv
// ----------------------------------------------------------------------------
// siku_ctrl: sequencing controller
// Walks each wheel through product, setup, cordic, gain and finish steps.
// ----------------------------------------------------------------------------
module siku_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  siku_pkg::status_t  status,
	output siku_pkg::cmd_t     cmd
);

	siku_pkg::state_t state_q, state_d;
	logic [1:0] wheel_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			siku_pkg::ST_IDLE:    if (s_tvalid) state_d = siku_pkg::ST_MUL;
			siku_pkg::ST_MUL:     state_d = siku_pkg::ST_PREP;
			siku_pkg::ST_PREP:    state_d = siku_pkg::ST_ROT;
			siku_pkg::ST_ROT:     if (status.rot_last) state_d = siku_pkg::ST_GAIN_LO;
			siku_pkg::ST_GAIN_LO: state_d = siku_pkg::ST_GAIN_HI;
			siku_pkg::ST_GAIN_HI: state_d = siku_pkg::ST_FINISH;
			siku_pkg::ST_FINISH: begin
				if (wheel_q == siku_pkg::LAST_WHEEL) state_d = siku_pkg::ST_PUBLISH;
				else state_d = siku_pkg::ST_MUL;
			end
			siku_pkg::ST_PUBLISH: if (status.out_free) state_d = siku_pkg::ST_IDLE;
			default:              state_d = siku_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd         = '0;
		cmd.wheel   = wheel_q;
		s_tready    = 1'b0;
		unique case (state_q)
			siku_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			siku_pkg::ST_MUL:     cmd.mul = 1'b1;
			siku_pkg::ST_PREP:    cmd.prep = 1'b1;
			siku_pkg::ST_ROT:     cmd.rot = 1'b1;
			siku_pkg::ST_GAIN_LO: cmd.gain_lo = 1'b1;
			siku_pkg::ST_GAIN_HI: cmd.gain_hi = 1'b1;
			siku_pkg::ST_FINISH:  cmd.finish = 1'b1;
			siku_pkg::ST_PUBLISH: cmd.publish = status.out_free;
			default:              cmd = '0;
		endcase
	end

	// state and wheel counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= siku_pkg::ST_IDLE;
			wheel_q <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.load) wheel_q <= '0;
			else if (cmd.finish && wheel_q != siku_pkg::LAST_WHEEL) wheel_q <= wheel_q + 2'd1;
		end
	end

`ifndef SYNTHESIS
	a_load_starts: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == siku_pkg::ST_MUL)
		else $error("accepted item did not start wheel processing");
	a_publish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish |-> status.out_free)
		else $error("result published over a pending transfer");
	a_wheel_range: assert property (@(posedge clk) disable iff (!arst_n)
		wheel_q != 2'd3)
		else $error("wheel counter out of range");
	a_publish_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == siku_pkg::ST_PUBLISH) |-> $past(wheel_q) == siku_pkg::LAST_WHEEL)
		else $error("publish before last wheel");
`endif

endmodule

// File: src/siku_dp.sv
// ----------------------------------------------------------------------------
// siku_dp: kinematics datapath
// Wheel velocity, iterative vectoring cordic, gain, speed and held angles.
// ----------------------------------------------------------------------------
module siku_dp #(
	parameter int CORDIC_STAGES = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic [47:0]        s_tdata,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [95:0]        m_tdata,
	input  siku_pkg::cmd_t     cmd,
	output siku_pkg::status_t  status
);

	localparam int KW = $clog2(CORDIC_STAGES);
	localparam logic [KW-1:0] K_LAST = KW'(CORDIC_STAGES - 1);
	localparam int XW_L = siku_pkg::XW;
	localparam int ZW_L = siku_pkg::ZW;

	// round v/4096 half away from zero
	function automatic logic signed [20:0] rnd12(input logic signed [31:0] v);
		logic [32:0] a;
		logic [32:0] s;
		logic [20:0] r;
		a = v[31] ? (33'd0 - {v[31], v}) : {v[31], v};
		s = a + 33'd2048;
		r = s[32:12];
		return v[31] ? (21'd0 - r) : r;
	endfunction

	logic [15:0] pos_q [6];
	logic [15:0] inv_r_q, limit_q;
	logic signed [15:0] vx_q, vy_q, wz_q;
	logic signed [31:0] px_q, py_q;
	logic signed [XW_L-1:0] x_q, y_q;
	logic signed [ZW_L-1:0] z_q;
	logic [KW-1:0] k_q;
	logic [59:0] acc_q;
	logic [15:0] held_q [3];
	logic [15:0] ang_res_q [3];
	logic [14:0] spd_res_q [3];
	logic [95:0] m_tdata_q;
	logic m_tvalid_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) pos_q[i] <= '0;
			inv_r_q <= siku_pkg::INV_RADIUS_RST;
			limit_q <= siku_pkg::LOW_SPEED_RST;
		end else if (cfg_we) begin
			if (cfg_index == siku_pkg::REG_INV_RADIUS) inv_r_q <= cfg_data;
			else if (cfg_index == siku_pkg::REG_LOW_SPEED) limit_q <= cfg_data;
			else pos_q[cfg_index - siku_pkg::REG_W0_POS_X] <= cfg_data;
		end
	end

	// wheel position selection
	logic signed [15:0] rx, ry;
	assign rx = pos_q[{cmd.wheel, 1'b0}];
	assign ry = pos_q[{cmd.wheel, 1'b1}];

	// wheel velocity and cordic setup
	logic signed [21:0] vix, viy;
	logic signed [XW_L-1:0] x0, y0;
	assign vix = 22'(vx_q) - 22'(rnd12(py_q));
	assign viy = 22'(vy_q) + 22'(rnd12(px_q));
	assign x0  = XW_L'($signed({vix, 8'd0}));
	assign y0  = XW_L'($signed({viy, 8'd0}));

	// cordic micro-rotation
	logic signed [XW_L-1:0] xs, ys;
	logic signed [ZW_L-1:0] atan_k;
	assign xs = x_q >>> k_q;
	assign ys = y_q >>> k_q;
	assign atan_k = ZW_L'(siku_pkg::ATAN_TAB[5'(k_q)]);

	// gain partial products
	logic [44:0] pgain;
	assign pgain = cmd.gain_lo ? (x_q[14:0] * siku_pkg::GAIN_Q30)
	                           : (x_q[29:15] * siku_pkg::GAIN_Q30);

	// magnitude, speed and angle
	logic [29:0] mag18;
	logic [30:0] mag_sum;
	logic [22:0] mag10;
	logic [45:0] spd_prod;
	logic [46:0] spd_sum;
	logic [28:0] spd_raw;
	logic [14:0] spd;
	logic [ZW_L-1:0] z_abs;
	logic [ZW_L:0] z_sum;
	logic [15:0] z_rnd, ang_new;
	logic above;
	assign mag18    = acc_q[59:30];
	assign mag_sum  = {1'b0, mag18} + 31'd128;
	assign mag10    = mag_sum[30:8];
	assign above    = mag10 > {7'd0, limit_q};
	assign spd_prod = mag18 * inv_r_q;
	assign spd_sum  = {1'b0, spd_prod} + 47'd131072;
	assign spd_raw  = spd_sum[46:18];
	assign spd      = (spd_raw > {14'd0, siku_pkg::SPEED_MAX}) ? siku_pkg::SPEED_MAX
	                                                         : spd_raw[14:0];
	assign z_abs    = z_q[ZW_L-1] ? (ZW_L'(0) - z_q) : z_q;
	assign z_sum    = {1'b0, z_abs} + (ZW_L+1)'(32768);
	assign z_rnd    = z_sum[31:16];
	assign ang_new  = z_q[ZW_L-1] ? (16'd0 - z_rnd) : z_rnd;

	// datapath registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			vx_q <= s_tdata[15:0];
			vy_q <= s_tdata[31:16];
			wz_q <= s_tdata[47:32];
		end
		if (cmd.mul) begin
			px_q <= wz_q * rx;
			py_q <= wz_q * ry;
		end
		if (cmd.prep) begin
			k_q <= '0;
			if (vix < 0) begin
				x_q <= XW_L'(0) - x0;
				y_q <= XW_L'(0) - y0;
				z_q <= (viy >= 0) ? ZW_L'(64'sd2147483648) : ZW_L'(-64'sd2147483648);
			end else begin
				x_q <= x0;
				y_q <= y0;
				z_q <= '0;
			end
		end
		if (cmd.rot) begin
			k_q <= k_q + KW'(1);
			if (!y_q[XW_L-1]) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + atan_k;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - atan_k;
			end
		end
		if (cmd.gain_lo) acc_q <= {15'd0, pgain};
		if (cmd.gain_hi) acc_q <= acc_q + {pgain, 15'd0};
		if (cmd.finish) begin
			ang_res_q[cmd.wheel] <= above ? ang_new : held_q[cmd.wheel];
			spd_res_q[cmd.wheel] <= spd;
		end
		if (cmd.publish) begin
			m_tdata_q <= {3'd0, spd_res_q[2], spd_res_q[1], spd_res_q[0],
			              ang_res_q[2], ang_res_q[1], ang_res_q[0]};
		end
	end

	// held steer angles
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < siku_pkg::NUM_WHEELS; i++) held_q[i] <= '0;
		end else if (cmd.finish && above) begin
			held_q[cmd.wheel] <= ang_new;
		end
	end

	// output transfer valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.publish) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid        = m_tvalid_q;
	assign m_tdata         = m_tdata_q;
	assign status.out_free = !m_tvalid_q || m_tready;
	assign status.rot_last = (k_q == K_LAST);

`ifndef SYNTHESIS
	a_x_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cmd.rot) |-> !x_q[XW_L-1])
		else $error("cordic x went negative");
	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q && !m_tready |=> m_tvalid_q && $stable(m_tdata_q))
		else $error("pending result changed");
	a_speed_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> spd <= siku_pkg::SPEED_MAX)
		else $error("speed above clamp");
`endif

endmodule

// File: src/swerve_inverse_kinematics_unit.sv
// ----------------------------------------------------------------------------
// swerve_inverse_kinematics_unit: three-wheel swerve inverse kinematics
// Each accepted input runs the three wheels in turn, one cordic rotation per cycle
// for each wheel; the result is registered and held on the output until taken.
// New input waits until the result is published, which needs a free output.
// Reset: arst_n restores control, held angles, output valid and config registers.
// ----------------------------------------------------------------------------
module swerve_inverse_kinematics_unit #(
	parameter int CORDIC_STAGES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // vel_x, vel_y, yaw_rate
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata    // angle_w0..w2, speed_w0..w2 (15b each), 3b zero
);

	siku_pkg::cmd_t    cmd;
	siku_pkg::status_t status;

	// sequencing controller
	siku_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// arithmetic datapath
	siku_dp #(
		.CORDIC_STAGES (CORDIC_STAGES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cmd       (cmd),
		.status    (status)
	);

endmodule

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: swerve inverse kinematics unit
// Drives chassis velocity commands over the input stream, predicts the steer
// angle and wheel speed of each wheel and compares every result transfer.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_STAGES = 16;
	localparam int WATCHDOG_LIMIT = 4000;

	typedef struct packed {
		logic [15:0] angle_w0;
		logic [15:0] angle_w1;
		logic [15:0] angle_w2;
		logic [14:0] speed_w0;
		logic [14:0] speed_w1;
		logic [14:0] speed_w2;
	} wheel_cmd_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;   // vel_x, vel_y, yaw_rate
	logic        m_tvalid;
	logic        m_tready;
	logic [95:0] m_tdata;   // angle_w0..w2, speed_w0..w2 (15b each), 3b zero

	// predictor copy of registers and held angles
	logic [15:0] reg_shadow [8];
	logic [15:0] held_shadow [3];
	wheel_cmd_t  expected_cmds [$];
	int          mismatches;
	int          results_seen;
	int          items_sent;
	int          idle_cycles;
	int          ready_wait;

	swerve_inverse_kinematics_unit #(.CORDIC_STAGES(N_STAGES)) u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// round half away from zero by 2^s
	function automatic longint round_away(longint v, int s);
		longint half;
		half = longint'(1) << (s - 1);
		if (v >= 0)
			return (v + half) >>> s;
		return -((-v + half) >>> s);
	endfunction

	// steer angle and speed of every wheel for one command
	function automatic wheel_cmd_t solve_wheels(logic [15:0] vx_in, logic [15:0] vy_in,
			logic [15:0] wz_in);
		wheel_cmd_t r;
		longint vx, vy, wz, rx, ry, x, y, z, xs, ys, mag18, mag10, spd;
		logic [15:0] ang [3];
		logic [14:0] spdv [3];
		vx = longint'($signed(vx_in));
		vy = longint'($signed(vy_in));
		wz = longint'($signed(wz_in));
		for (int w = 0; w < 3; w++) begin
			rx = longint'($signed(reg_shadow[2 * w]));
			ry = longint'($signed(reg_shadow[2 * w + 1]));
			x = (vx - round_away(wz * ry, 12)) * 256;
			y = (vy + round_away(wz * rx, 12)) * 256;
			z = 0;
			if (x < 0) begin
				z = (y >= 0) ? (longint'(1) << 31) : -(longint'(1) << 31);
				x = -x;
				y = -y;
			end
			for (int k = 0; k < N_STAGES; k++) begin
				xs = x >>> k;
				ys = y >>> k;
				if (y >= 0) begin
					x += ys;
					y -= xs;
					z += longint'(siku_pkg::ATAN_TAB[k]);
				end else begin
					x -= ys;
					y += xs;
					z -= longint'(siku_pkg::ATAN_TAB[k]);
				end
			end
			mag18 = (x * longint'(siku_pkg::GAIN_Q30)) >>> 30;
			mag10 = (mag18 + 128) >>> 8;
			if (mag10 > longint'(reg_shadow[siku_pkg::REG_LOW_SPEED]))
				held_shadow[w] = 16'(round_away(z, 16));
			ang[w] = held_shadow[w];
			spd = (mag18 * longint'(reg_shadow[siku_pkg::REG_INV_RADIUS])
				+ (longint'(1) << 17)) >>> 18;
			if (spd > longint'(siku_pkg::SPEED_MAX))
				spd = longint'(siku_pkg::SPEED_MAX);
			spdv[w] = 15'(spd);
		end
		r.angle_w0 = ang[0];
		r.angle_w1 = ang[1];
		r.angle_w2 = ang[2];
		r.speed_w0 = spdv[0];
		r.speed_w1 = spdv[1];
		r.speed_w2 = spdv[2];
		return r;
	endfunction

	// write one register while the block is idle
	task automatic write_reg(logic [2:0] idx, logic [15:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		reg_shadow[idx] = val;
	endtask

	// one command transfer after a random gap
	task automatic send_command(logic [15:0] vx, logic [15:0] vy, logic [15:0] wz);
		int gap;
		gap = $urandom_range(0, 6);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		repeat (gap) @(posedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= {wz, vy, vx};
		do @(posedge clk); while (!s_tready);
		expected_cmds.push_back(solve_wheels(vx, vy, wz));
		items_sent++;
		s_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		while (expected_cmds.size() != 0) @(posedge clk);
		repeat (3 * (N_STAGES + 5) + 8) @(posedge clk);
	endtask

	function automatic logic [15:0] rand_pos();
		case ($urandom_range(0, 3))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'($signed($urandom_range(0, 8192)) - 4096);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] rand_vel();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'($signed($urandom_range(0, 40)) - 20);
			3: return 16'h0000;
			default: return 16'($urandom);
		endcase
	endfunction

	// extremes, zero vector, angle of pi, default and extreme registers
	task automatic test_directed();
		send_command(16'h0000, 16'h0000, 16'h0000);
		send_command(16'h0400, 16'h0000, 16'h0000);
		send_command(16'h0000, 16'h0400, 16'h0000);
		send_command(16'hfc00, 16'h0000, 16'h0000);
		send_command(16'hfc00, 16'hffff, 16'h0000);
		send_command(16'h0000, 16'hfc00, 16'h0000);
		send_command(16'h0005, 16'h0003, 16'h0000);
		send_command(16'h7fff, 16'h7fff, 16'h7fff);
		send_command(16'h8000, 16'h8000, 16'h8000);
		send_command(16'h8000, 16'h7fff, 16'h0000);
		wait_drained();
		write_reg(siku_pkg::REG_W0_POS_X, 16'h7fff);
		write_reg(siku_pkg::REG_W0_POS_Y, 16'h8000);
		write_reg(siku_pkg::REG_W1_POS_X, 16'h8000);
		write_reg(siku_pkg::REG_W1_POS_Y, 16'h7fff);
		write_reg(siku_pkg::REG_W2_POS_X, 16'h1000);
		write_reg(siku_pkg::REG_W2_POS_Y, 16'hf000);
		write_reg(siku_pkg::REG_INV_RADIUS, 16'hffff);
		write_reg(siku_pkg::REG_LOW_SPEED, 16'h0000);
		send_command(16'h0000, 16'h0000, 16'h0400);
		send_command(16'h0000, 16'h0000, 16'h7fff);
		send_command(16'h0000, 16'h0000, 16'h8000);
		send_command(16'h7fff, 16'h8000, 16'h7fff);
		send_command(16'h0000, 16'h0000, 16'h0000);
		wait_drained();
		write_reg(siku_pkg::REG_INV_RADIUS, 16'h0000);
		write_reg(siku_pkg::REG_LOW_SPEED, 16'hffff);
		send_command(16'h1234, 16'hedcb, 16'h0100);
		send_command(16'h7fff, 16'h7fff, 16'h7fff);
		wait_drained();
	endtask

	// random commands over several register settings
	task automatic test_random(int phases, int per_phase);
		for (int p = 0; p < phases; p++) begin
			for (int r = 0; r < 6; r++)
				write_reg(siku_pkg::REG_W0_POS_X + 3'(r), rand_pos());
			write_reg(siku_pkg::REG_INV_RADIUS, ($urandom_range(0, 3) == 0) ? 16'($urandom)
				: 16'($urandom_range(1, 8000)));
			write_reg(siku_pkg::REG_LOW_SPEED, ($urandom_range(0, 3) == 0) ? 16'($urandom)
				: 16'($urandom_range(0, 50)));
			for (int i = 0; i < per_phase; i++) begin
				send_command(rand_vel(), rand_vel(), rand_vel());
				// sender holds off until the pipe empties
				if (i == per_phase / 2)
					while (expected_cmds.size() != 0) @(posedge clk);
			end
			wait_drained();
		end
	endtask

	// output ready, idle for a random count of cycles before each transfer
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			ready_wait = $urandom_range(0, 6);
		end else if (m_tvalid && m_tready) begin
			ready_wait = $urandom_range(0, 6);
			m_tready <= (ready_wait == 0);
		end else if (ready_wait > 0) begin
			ready_wait--;
			m_tready <= (ready_wait == 0);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// result checking and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout after %0d idle cycles", idle_cycles);
				$display("testbench: FAIL");
				$finish;
			end
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (expected_cmds.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result transfer %h", m_tdata);
				end else begin
					wheel_cmd_t e, a;
					e = expected_cmds.pop_front();
					a.angle_w0 = m_tdata[15:0];
					a.angle_w1 = m_tdata[31:16];
					a.angle_w2 = m_tdata[47:32];
					a.speed_w0 = m_tdata[62:48];
					a.speed_w1 = m_tdata[77:63];
					a.speed_w2 = m_tdata[92:78];
					if (a !== e || m_tdata[95:93] !== 3'b000) begin
						mismatches++;
						if (mismatches <= 10)
							$display("result %0d: expected ang %0d %0d %0d spd %0d %0d %0d,",
								results_seen, $signed(e.angle_w0), $signed(e.angle_w1),
								$signed(e.angle_w2), e.speed_w0, e.speed_w1, e.speed_w2,
								" got ang %0d %0d %0d spd %0d %0d %0d",
								$signed(a.angle_w0), $signed(a.angle_w1),
								$signed(a.angle_w2), a.speed_w0, a.speed_w1, a.speed_w2);
					end
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		mismatches = 0;
		results_seen = 0;
		items_sent = 0;
		idle_cycles = 0;
		for (int i = 0; i < 8; i++)
			reg_shadow[i] = 16'h0000;
		reg_shadow[siku_pkg::REG_INV_RADIUS] = siku_pkg::INV_RADIUS_RST;
		reg_shadow[siku_pkg::REG_LOW_SPEED] = siku_pkg::LOW_SPEED_RST;
		for (int i = 0; i < 3; i++)
			held_shadow[i] = 16'h0000;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(9, 48);
		wait_drained();
		$display("covered %0d commands, %0d results over directed extremes and 9 random",
			items_sent, results_seen);
		$display("register settings with random stalls on both streams");
		if (mismatches == 0 && expected_cmds.size() == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
